>>> src/assert_macros.svh
// Assertion macros shared by the frame ring queue RTL.
// Both macros sample on the rising edge of clk_i.
// Both macros are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FRQ_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define FRQ_ASSERT(lbl, prop, msg)

`define FRQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/frq_pkg.sv
package frq_pkg;

  localparam int unsigned DEF_SLOT_COUNT    = 8;
  localparam int unsigned DEF_MAX_FRAME_LEN = 64;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OFFSET_W  = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned HEADLEN_W = 7;
  localparam int unsigned COUNT_W   = 3;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OFFSET = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_byte;
    logic                last_byte;
    logic [OFFSET_W-1:0] read_offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 rd_ok;
    logic [HEADLEN_W-1:0] head_length;
    logic [COUNT_W-1:0]   frame_count;
  } res_t;

endpackage

>>> src/frq_ram.sv
module frq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/frq_ctrl.sv
`include "assert_macros.svh"

module frq_ctrl #(
  parameter int unsigned SLOT_COUNT    = frq_pkg::DEF_SLOT_COUNT,
  parameter int unsigned MAX_FRAME_LEN = frq_pkg::DEF_MAX_FRAME_LEN,
  localparam int unsigned ADDR_W = $clog2(SLOT_COUNT * MAX_FRAME_LEN)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  frq_pkg::req_t                    req_i,
  output frq_pkg::res_t                    res_o,
  output logic                             mem_we_o,
  output logic [ADDR_W-1:0]                mem_waddr_o,
  output logic [frq_pkg::DATA_W-1:0]       mem_wdata_o,
  output logic [ADDR_W-1:0]                mem_raddr_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned LEN_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int unsigned CMP_W  = (LEN_W > frq_pkg::OFFSET_W) ? LEN_W : frq_pkg::OFFSET_W;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ASSEMBLE,
    MODE_DROP_FULL,
    MODE_DROP_LONG
  } mode_e;

  mode_e                       mode_q, mode_d, mode_eff;
  logic [LEN_W-1:0]            fill_q, fill_d, fill_eff;
  logic [SLOT_W-1:0]           wslot_q, wslot_d;
  logic [SLOT_W-1:0]           rslot_q, rslot_d;
  logic [LEN_W-1:0]            head_len_q, head_len_d;
  logic [LEN_W-1:0]            len_q [SLOT_COUNT];
  logic                        len_we;
  logic [LEN_W-1:0]            len_wdata;
  logic [frq_pkg::STATUS_W-1:0] res_status;
  logic                        res_rd_ok;
  logic                        empty, empty_after, full;
  logic [SLOT_W:0]             count_after;

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = '0;
    if (s != SLOT_W'(SLOT_COUNT - 1)) begin
      n = s + 1'b1;
    end
    return n;
  endfunction

  assign empty = (wslot_q == rslot_q);
  assign full  = (slot_after(wslot_q) == rslot_q);

  always_comb begin
    mode_d     = mode_q;
    fill_d     = fill_q;
    wslot_d    = wslot_q;
    rslot_d    = rslot_q;
    head_len_d = head_len_q;
    len_we     = 1'b0;
    len_wdata  = '0;
    mode_eff   = mode_q;
    fill_eff   = fill_q;
    mem_we_o   = 1'b0;
    res_status = frq_pkg::ST_OK;
    res_rd_ok  = 1'b0;

    unique case (req_i.action)
      frq_pkg::ACT_PUSH: begin
        if (mode_q == MODE_IDLE) begin
          fill_eff = '0;
          mode_eff = full ? MODE_DROP_FULL : MODE_ASSEMBLE;
        end
        fill_d = fill_eff;
        mode_d = mode_eff;
        if (mode_eff == MODE_ASSEMBLE) begin
          if (fill_eff < LEN_W'(MAX_FRAME_LEN)) begin
            mem_we_o = fire_i;
            fill_d   = fill_eff + 1'b1;
          end else begin
            mode_d = MODE_DROP_LONG;
          end
        end
        if (req_i.last_byte) begin
          unique case (mode_d)
            MODE_ASSEMBLE: begin
              len_we    = fire_i;
              len_wdata = fill_d;
              wslot_d   = slot_after(wslot_q);
              if (empty) begin
                head_len_d = fill_d;
              end
            end
            MODE_DROP_FULL: res_status = frq_pkg::ST_FULL;
            default:        res_status = frq_pkg::ST_LONG;
          endcase
          mode_d = MODE_IDLE;
          fill_d = '0;
        end
      end
      frq_pkg::ACT_READ: begin
        if (empty) begin
          res_status = frq_pkg::ST_EMPTY;
        end else if (CMP_W'(req_i.read_offset) >= CMP_W'(head_len_q)) begin
          res_status = frq_pkg::ST_OFFSET;
        end else begin
          res_rd_ok = 1'b1;
        end
      end
      frq_pkg::ACT_POP: begin
        if (empty) begin
          res_status = frq_pkg::ST_EMPTY;
        end else begin
          rslot_d    = slot_after(rslot_q);
          head_len_d = len_q[slot_after(rslot_q)];
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_after = (wslot_d == rslot_d);
  assign count_after = (wslot_d >= rslot_d) ?
                       ({1'b0, wslot_d} - {1'b0, rslot_d}) :
                       ((SLOT_W + 1)'(SLOT_COUNT) - {1'b0, rslot_d} + {1'b0, wslot_d});

  assign res_o = {res_status, res_rd_ok,
                  (empty_after ? frq_pkg::HEADLEN_W'(0) : frq_pkg::HEADLEN_W'(head_len_d)),
                  frq_pkg::COUNT_W'(count_after)};

  assign mem_waddr_o = ADDR_W'(wslot_q) * ADDR_W'(MAX_FRAME_LEN) + ADDR_W'(fill_eff);
  assign mem_wdata_o = req_i.data_byte;
  assign mem_raddr_o = ADDR_W'(rslot_q) * ADDR_W'(MAX_FRAME_LEN) + ADDR_W'(req_i.read_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      fill_q  <= '0;
      wslot_q <= '0;
      rslot_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      fill_q  <= fill_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      head_len_q <= head_len_d;
    end
    if (len_we) begin
      len_q[wslot_q] <= len_wdata;
    end
  end

  `FRQ_ASSERT(a_fill_bound, (fill_q <= LEN_W'(MAX_FRAME_LEN)), "fill count beyond frame limit")
  `FRQ_ASSERT(a_write_on_push, (mem_we_o |-> (fire_i && req_i.action == frq_pkg::ACT_PUSH)), "byte write outside a push")
  `FRQ_ASSERT_NEXT(a_publish_adv, (len_we), (wslot_q != $past(wslot_q) && mode_q == MODE_IDLE), "publish did not advance the write slot")
  `FRQ_ASSERT_NEXT(a_pop_adv, (fire_i && req_i.action == frq_pkg::ACT_POP && !empty), (rslot_q != $past(rslot_q)), "pop did not advance the read slot")

endmodule

>>> src/frame_ring_queue.sv
// A request waits in the input register; when it fires, its result is registered.
// Throughput: one request per cycle, held back only by the result side.
// The byte store is one RAM with a registered read port; it sets the second stage.
// Reset clears the slot pointers, the frame assembly state and both valid flags.
// The byte store and the frame length table are not cleared; they are written before use.
module frame_ring_queue #(
  parameter int unsigned SLOT_COUNT    = frq_pkg::DEF_SLOT_COUNT,
  parameter int unsigned MAX_FRAME_LEN = frq_pkg::DEF_MAX_FRAME_LEN
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [frq_pkg::ACTION_W-1:0]     action_i,
  input  logic [frq_pkg::DATA_W-1:0]       data_byte_i,
  input  logic                             last_byte_i,
  input  logic [frq_pkg::OFFSET_W-1:0]     read_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [frq_pkg::STATUS_W-1:0]     status_o,
  output logic [frq_pkg::DATA_W-1:0]       read_data_o,
  output logic [frq_pkg::HEADLEN_W-1:0]    head_length_o,
  output logic [frq_pkg::COUNT_W-1:0]      frame_count_o
);

  localparam int unsigned DEPTH  = SLOT_COUNT * MAX_FRAME_LEN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic                       in_valid_q;
  frq_pkg::req_t              req_q;
  logic                       out_valid_q;
  frq_pkg::res_t              res_q;
  frq_pkg::res_t              res;
  logic                       advance, fire;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [frq_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      req_q.action      <= action_i;
      req_q.data_byte   <= data_byte_i;
      req_q.last_byte   <= last_byte_i;
      req_q.read_offset <= read_offset_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  frq_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (req_q),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr)
  );

  frq_ram #(
    .WIDTH(frq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_bytes (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (fire),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign read_data_o   = res_q.rd_ok ? mem_rdata : '0;
  assign head_length_o = res_q.head_length;
  assign frame_count_o = res_q.frame_count;

endmodule

>>> tb/frame_ring_queue_tb.sv
`timescale 1ns / 100ps

module frame_ring_queue_tb;

  localparam int unsigned SLOTS        = frq_pkg::DEF_SLOT_COUNT;
  localparam int unsigned MAXLEN       = frq_pkg::DEF_MAX_FRAME_LEN;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned IDLE_PCT     = 13;

  localparam logic [frq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [frq_pkg::STATUS_W-1:0]  status;
    logic [frq_pkg::DATA_W-1:0]    read_data;
    logic [frq_pkg::HEADLEN_W-1:0] head_length;
    logic [frq_pkg::COUNT_W-1:0]   frame_count;
  } frame_result_t;

  // A push row with copies above one sends a whole frame of incrementing bytes.
  typedef struct packed {
    logic [frq_pkg::ACTION_W-1:0] action;
    logic [frq_pkg::DATA_W-1:0]   data_byte;
    logic                         last_byte;
    logic [frq_pkg::OFFSET_W-1:0] read_offset;
    logic [6:0]                   copies;
    logic                         typed;
    frame_result_t                want;
  } stim_row_t;

  typedef enum logic [1:0] {
    ASM_IDLE,
    ASM_BUILD,
    ASM_DROP_FULL,
    ASM_DROP_LONG
  } asm_mode_e;

  localparam stim_row_t DIRECTED [ROWS] = '{
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_EMPTY,  8'h00, 7'd0, 3'd0}},
    '{frq_pkg::ACT_POP,  8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_EMPTY,  8'h00, 7'd0, 3'd0}},
    '{ACT_UNUSED,        8'hff, 1'b1, 6'd63, 7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'h00, 7'd0, 3'd0}},
    '{frq_pkg::ACT_PUSH, 8'hff, 1'b1, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'h00, 7'd1, 3'd1}},
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'hff, 7'd1, 3'd1}},
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd63, 7'd1,  1'b1,
      '{frq_pkg::ST_OFFSET, 8'h00, 7'd1, 3'd1}},
    '{frq_pkg::ACT_POP,  8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'h00, 7'd0, 3'd0}},
    '{frq_pkg::ACT_PUSH, 8'h00, 1'b1, 6'd0,  7'd64, 1'b0, '0},
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd63, 7'd1,  1'b0, '0},
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h80, 1'b1, 6'd0,  7'd65, 1'b0, '0},
    '{frq_pkg::ACT_POP,  8'h00, 1'b0, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h01, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h02, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h04, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h08, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h10, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h20, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h40, 1'b1, 6'd0,  7'd1,  1'b0, '0},
    '{frq_pkg::ACT_PUSH, 8'h5a, 1'b1, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_FULL,   8'h00, 7'd1, 3'd7}},
    '{frq_pkg::ACT_PUSH, 8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'h00, 7'd1, 3'd7}},
    '{frq_pkg::ACT_POP,  8'h00, 1'b0, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_OK,     8'h00, 7'd1, 3'd6}},
    '{frq_pkg::ACT_PUSH, 8'ha5, 1'b1, 6'd0,  7'd1,  1'b1,
      '{frq_pkg::ST_FULL,   8'h00, 7'd1, 3'd6}},
    '{frq_pkg::ACT_PUSH, 8'h3c, 1'b1, 6'd0,  7'd3,  1'b0, '0},
    '{frq_pkg::ACT_READ, 8'h00, 1'b0, 6'd0,  7'd1,  1'b0, '0}
  };

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [frq_pkg::ACTION_W-1:0]  action_i      = frq_pkg::ACT_PUSH;
  logic [frq_pkg::DATA_W-1:0]    data_byte_i   = '0;
  logic                          last_byte_i   = 1'b0;
  logic [frq_pkg::OFFSET_W-1:0]  read_offset_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [frq_pkg::STATUS_W-1:0]  status_o;
  logic [frq_pkg::DATA_W-1:0]    read_data_o;
  logic [frq_pkg::HEADLEN_W-1:0] head_length_o;
  logic [frq_pkg::COUNT_W-1:0]   frame_count_o;

  logic [frq_pkg::DATA_W-1:0]    byte_store [SLOTS*MAXLEN];
  logic [frq_pkg::HEADLEN_W-1:0] len_table [SLOTS];
  logic [2:0]                    wr_slot = '0;
  logic [2:0]                    rd_slot = '0;
  logic [6:0]                    fill    = '0;
  asm_mode_e                     mode    = ASM_IDLE;

  frame_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles   = 0;
  bit            calm           = 1'b0;

  frame_ring_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .read_offset_i (read_offset_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .head_length_o (head_length_o),
    .frame_count_o (frame_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [2:0] next_slot(input logic [2:0] slot);
    return (slot == 3'(SLOTS - 1)) ? 3'd0 : slot + 3'd1;
  endfunction

  function automatic frame_result_t predict_frame_queue(input frq_pkg::req_t r);
    frame_result_t res;
    logic          empty;
    res   = '0;
    empty = (wr_slot == rd_slot);
    case (r.action)
      frq_pkg::ACT_PUSH: begin
        if (mode == ASM_IDLE) begin
          fill = '0;
          mode = (next_slot(wr_slot) == rd_slot) ? ASM_DROP_FULL : ASM_BUILD;
        end
        if (mode == ASM_BUILD) begin
          if (fill < MAXLEN) begin
            byte_store[wr_slot*MAXLEN + fill] = r.data_byte;
            fill++;
          end else begin
            mode = ASM_DROP_LONG;
          end
        end
        if (r.last_byte) begin
          case (mode)
            ASM_BUILD: begin
              len_table[wr_slot] = fill;
              wr_slot = next_slot(wr_slot);
            end
            ASM_DROP_FULL: res.status = frq_pkg::ST_FULL;
            default: res.status = frq_pkg::ST_LONG;
          endcase
          mode = ASM_IDLE;
          fill = '0;
        end
      end
      frq_pkg::ACT_READ: begin
        if (empty) begin
          res.status = frq_pkg::ST_EMPTY;
        end else if (r.read_offset >= len_table[rd_slot]) begin
          res.status = frq_pkg::ST_OFFSET;
        end else begin
          res.read_data = byte_store[rd_slot*MAXLEN + r.read_offset];
        end
      end
      frq_pkg::ACT_POP: begin
        if (empty) begin
          res.status = frq_pkg::ST_EMPTY;
        end else begin
          rd_slot = next_slot(rd_slot);
        end
      end
      default: ;
    endcase
    res.head_length = (wr_slot == rd_slot) ? '0 : len_table[rd_slot];
    res.frame_count = 3'(wr_slot - rd_slot);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input frq_pkg::req_t r, input logic typed,
                              input frame_result_t want);
    frame_result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= r.action;
    data_byte_i   <= r.data_byte;
    last_byte_i   <= r.last_byte;
    read_offset_i <= r.read_offset;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_frame_queue(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", status_o, want.status);
        end
        if (read_data_o !== want.read_data) begin
          report_mismatch("read_data", read_data_o, want.read_data);
        end
        if (head_length_o !== want.head_length) begin
          report_mismatch("head_length", head_length_o, want.head_length);
        end
        if (frame_count_o !== want.frame_count) begin
          report_mismatch("frame_count", frame_count_o, want.frame_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    frq_pkg::req_t r;
    stim_row_t     row;
    int unsigned   frame_left;
    int unsigned   counted;
    int unsigned   pick;
    int unsigned   kind;
    int unsigned   len_sel;
    bit            fill_bias;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ROWS; i++) begin
      row = DIRECTED[i];
      for (int k = 0; k < row.copies; k++) begin
        r.action      = row.action;
        r.data_byte   = row.data_byte + 8'(k);
        r.last_byte   = (k == row.copies - 1) ? row.last_byte : 1'b0;
        r.read_offset = row.read_offset;
        send_request(r, row.typed, row.want);
      end
    end

    // Mostly whole frames with random content; reads and pops are mixed in,
    // and stray bytes or unused codes break the sequences now and then.
    frame_left = 0;
    counted    = 0;
    while (counted < RANDOM_ITEMS) begin
      calm          = (counted >= 500 && counted < 650);
      fill_bias     = ((counted / 150) % 2) == 0;
      pick          = $urandom_range(99);
      r.data_byte   = 8'($urandom);
      r.last_byte   = 1'($urandom);
      r.read_offset = 6'($urandom);
      if (frame_left == 0 && pick < (fill_bias ? 45 : 20)) begin
        len_sel = $urandom_range(99);
        if (len_sel < 85) begin
          frame_left = $urandom_range(8, 1);
        end else if (len_sel < 95) begin
          frame_left = $urandom_range(40, 9);
        end else begin
          frame_left = $urandom_range(66, 62);
        end
      end
      if (frame_left != 0 && pick < 80) begin
        r.action    = frq_pkg::ACT_PUSH;
        r.last_byte = (frame_left == 1);
        frame_left--;
      end else begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          r.action = frq_pkg::ACT_READ;
          if (kind < 35 && wr_slot != rd_slot) begin
            r.read_offset = 6'($urandom_range(len_table[rd_slot] - 1));
          end
        end else if (kind < 85) begin
          r.action = frq_pkg::ACT_POP;
        end else if (kind < 93) begin
          r.action = ACT_UNUSED;
        end else begin
          r.action = frq_pkg::ACT_PUSH;
          if (r.last_byte) begin
            frame_left = 0;
          end
        end
      end
      send_request(r, 1'b0, '0);
      if (r.action != ACT_UNUSED) begin
        counted++;
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/frq_pkg.sv
src/frq_ram.sv
src/frq_ctrl.sv
src/frame_ring_queue.sv
tb/frame_ring_queue_tb.sv
